FILE: rtl/core/dpt_pkg.sv
package dpt_pkg;

  // The access address is 13 bits wide, and the page offset takes its low bits,
  // so the page number width and the page table depth follow from these two.
  localparam int VADDR_W     = 13;
  localparam int OFFSET_BITS = 2;
  localparam int VP_W        = VADDR_W - OFFSET_BITS;
  localparam int VIRT_PAGES  = 1 << VP_W;

  localparam int FRAMES_DEF     = 8;
  localparam int SWAP_SLOTS_DEF = 128;

endpackage

FILE: rtl/core/demand_paging_translator.sv
// A hit reads the page entry and gives its result from the lookup state, and the next item
// is taken only once the block is back in idle, so items never overlap. A fault into a
// free frame goes from lookup straight to fill; one with an eviction first reads the owner
// and then its page entry, and every frame that the clock policy passes over for its
// referenced bit repeats those two reads, since the page table memory has a single read port.
// Reset clears the page table in a pass over all VIRT_PAGES entries, during which no item is taken.
module demand_paging_translator #(
  parameter int FRAMES     = dpt_pkg::FRAMES_DEF,
  parameter int SWAP_SLOTS = dpt_pkg::SWAP_SLOTS_DEF,
  localparam int FRAME_W = $clog2(FRAMES),
  localparam int SLOT_W  = $clog2(SWAP_SLOTS)
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_wr_en,
  input  logic                                    cfg_wr_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [dpt_pkg::VADDR_W-1:0]             vaddr,
  input  logic                                    is_write,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [FRAME_W+dpt_pkg::OFFSET_BITS-1:0] paddr,
  output logic                                    fault,
  output logic [FRAME_W-1:0]                      frame,
  output logic                                    evicted,
  output logic [dpt_pkg::VP_W-1:0]                evicted_page,
  output logic                                    write_back,
  output logic [SLOT_W-1:0]                       write_slot,
  output logic                                    read_in,
  output logic [SLOT_W-1:0]                       read_slot,
  output logic                                    swap_full
);

  localparam int VP_W   = dpt_pkg::VP_W;
  localparam int OFF_W  = dpt_pkg::OFFSET_BITS;
  localparam int SW_W   = $clog2(2 * FRAMES + 1);
  localparam logic [SW_W-1:0] SWEEP_LAST = SW_W'(2 * FRAMES);

  typedef struct packed {
    logic              resident;
    logic              has_slot;
    logic              modified;
    logic              referenced;
    logic [FRAME_W-1:0] frame;
    logic [SLOT_W-1:0] slot;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               fault;
    logic               evicted;
    logic [VP_W-1:0]    ev_page;
    logic               wb;
    logic [SLOT_W-1:0]  wslot;
    logic               rd;
    logic [SLOT_W-1:0]  rslot;
    logic               full;
  } result_t;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_LOOKUP = 7'b0000100,
    S_OWNER  = 7'b0001000,
    S_VICTIM = 7'b0010000,
    S_FILL   = 7'b0100000,
    S_HOLD   = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic               mode;
  logic [VP_W-1:0]    clr_cnt, clr_cnt_next;
  logic [FRAME_W-1:0] hand, hand_next;
  logic [FRAME_W-1:0] cur, cur_next;
  logic [SW_W-1:0]    sweep, sweep_next;
  logic [FRAMES-1:0]  fr_valid, fr_valid_next;
  logic [VP_W-1:0]    vp;
  logic [OFF_W-1:0]   off;
  logic               wr;
  logic               vp_has_slot, vp_has_slot_next;
  logic [SLOT_W-1:0]  vp_slot, vp_slot_next;
  logic [VP_W-1:0]    op, op_next;
  logic               ev, ev_next;
  logic [VP_W-1:0]    ev_page, ev_page_next;
  logic               wb, wb_next;
  logic [SLOT_W-1:0]  wslot, wslot_next;
  logic               full, full_next;
  result_t            held, res;
  logic               finish;
  result_t            out_res;
  logic [OFF_W-1:0]   out_off;
  logic               out_free;

  logic               pt_we, pt_re;
  logic [VP_W-1:0]    pt_waddr, pt_raddr;
  entry_t             pt_wdata, pt_ent;
  logic [ENT_W-1:0]   pt_rdata;
  logic               fo_we, fo_re;
  logic [FRAME_W-1:0] fo_waddr, fo_raddr;
  logic [VP_W-1:0]    fo_wdata, fo_rdata;
  logic               slot_take, slot_avail;
  logic [SLOT_W-1:0]  slot_new;

  dpt_ram #(.WIDTH(ENT_W), .DEPTH(dpt_pkg::VIRT_PAGES)) u_page_mem (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .re    (pt_re),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  dpt_ram #(.WIDTH(VP_W), .DEPTH(FRAMES)) u_owner_mem (
    .clk   (clk),
    .we    (fo_we),
    .waddr (fo_waddr),
    .wdata (fo_wdata),
    .re    (fo_re),
    .raddr (fo_raddr),
    .rdata (fo_rdata)
  );

  dpt_slot_alloc #(.SWAP_SLOTS(SWAP_SLOTS)) u_slot_alloc (
    .clk   (clk),
    .rst   (rst),
    .take  (slot_take),
    .avail (slot_avail),
    .slot  (slot_new)
  );

  assign pt_ent   = pt_rdata;
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  function automatic logic [FRAME_W-1:0] hand_step(input logic [FRAME_W-1:0] h);
    hand_step = (h == FRAME_W'(FRAMES - 1)) ? '0 : h + FRAME_W'(1);
  endfunction

  always_comb begin
    state_next       = state;
    clr_cnt_next     = clr_cnt;
    hand_next        = hand;
    cur_next         = cur;
    sweep_next       = sweep;
    fr_valid_next    = fr_valid;
    vp_has_slot_next = vp_has_slot;
    vp_slot_next     = vp_slot;
    op_next          = op;
    ev_next          = ev;
    ev_page_next     = ev_page;
    wb_next          = wb;
    wslot_next       = wslot;
    full_next        = full;
    pt_we            = 1'b0;
    pt_waddr         = vp;
    pt_wdata         = '0;
    pt_re            = 1'b0;
    pt_raddr         = vaddr[dpt_pkg::VADDR_W-1:OFF_W];
    fo_we            = 1'b0;
    fo_waddr         = cur;
    fo_wdata         = vp;
    fo_re            = 1'b0;
    fo_raddr         = hand;
    slot_take        = 1'b0;
    finish           = 1'b0;
    res              = '0;

    case (state)
      S_CLEAR: begin
        pt_we    = 1'b1;
        pt_waddr = clr_cnt;
        clr_cnt_next = clr_cnt + VP_W'(1);
        if (clr_cnt == VP_W'(dpt_pkg::VIRT_PAGES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          pt_re      = 1'b1;
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        vp_has_slot_next = pt_ent.has_slot;
        vp_slot_next     = pt_ent.slot;
        ev_next          = 1'b0;
        ev_page_next     = '0;
        wb_next          = 1'b0;
        wslot_next       = '0;
        full_next        = 1'b0;
        if (pt_ent.resident) begin
          pt_we               = 1'b1;
          pt_wdata            = pt_ent;
          pt_wdata.referenced = 1'b1;
          pt_wdata.modified   = pt_ent.modified | wr;
          finish              = 1'b1;
          res.frame           = pt_ent.frame;
        end else begin
          // Both policies start at the hand; FIFO simply never skips a frame.
          cur_next   = hand;
          hand_next  = hand_step(hand);
          sweep_next = '0;
          if (!fr_valid[hand]) begin
            state_next = S_FILL;
          end else begin
            fo_re      = 1'b1;
            state_next = S_OWNER;
          end
        end
      end
      S_OWNER: begin
        op_next    = fo_rdata;
        pt_re      = 1'b1;
        pt_raddr   = fo_rdata;
        state_next = S_VICTIM;
      end
      S_VICTIM: begin
        pt_we    = 1'b1;
        pt_waddr = op;
        pt_wdata = pt_ent;
        if (mode && pt_ent.referenced && (sweep != SWEEP_LAST)) begin
          // Second chance: clear the bit and move on to the frame at the hand.
          pt_wdata.referenced = 1'b0;
          cur_next   = hand;
          hand_next  = hand_step(hand);
          sweep_next = sweep + SW_W'(1);
          if (!fr_valid[hand]) begin
            state_next = S_FILL;
          end else begin
            fo_re      = 1'b1;
            state_next = S_OWNER;
          end
        end else begin
          ev_next      = 1'b1;
          ev_page_next = op;
          if (pt_ent.has_slot) begin
            wb_next    = pt_ent.modified;
            wslot_next = pt_ent.modified ? pt_ent.slot : '0;
          end else if (slot_avail) begin
            slot_take         = 1'b1;
            wb_next           = 1'b1;
            wslot_next        = slot_new;
            pt_wdata.has_slot = 1'b1;
            pt_wdata.slot     = slot_new;
          end else begin
            full_next = 1'b1;
          end
          pt_wdata.resident   = 1'b0;
          pt_wdata.modified   = 1'b0;
          pt_wdata.referenced = 1'b0;
          state_next          = S_FILL;
        end
      end
      S_FILL: begin
        pt_we               = 1'b1;
        pt_wdata.resident   = 1'b1;
        pt_wdata.has_slot   = vp_has_slot;
        pt_wdata.modified   = wr;
        pt_wdata.referenced = 1'b1;
        pt_wdata.frame      = cur;
        pt_wdata.slot       = vp_slot;
        fo_we               = 1'b1;
        fr_valid_next[cur]  = 1'b1;
        finish              = 1'b1;
        res.frame           = cur;
        res.fault           = 1'b1;
        res.evicted         = ev;
        res.ev_page         = ev_page;
        res.wb              = wb;
        res.wslot           = wslot;
        res.rd              = vp_has_slot;
        res.rslot           = vp_has_slot ? vp_slot : '0;
        res.full            = full;
      end
      S_HOLD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (finish) begin
      state_next = out_free ? S_IDLE : S_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      hand      <= '0;
      fr_valid  <= '0;
      mode      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      clr_cnt  <= clr_cnt_next;
      hand     <= hand_next;
      fr_valid <= fr_valid_next;
      if (cfg_wr_en) begin
        mode <= cfg_wr_data;
      end
      if ((finish && out_free) || (state == S_HOLD && out_free)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur         <= cur_next;
    sweep       <= sweep_next;
    vp_has_slot <= vp_has_slot_next;
    vp_slot     <= vp_slot_next;
    op          <= op_next;
    ev          <= ev_next;
    ev_page     <= ev_page_next;
    wb          <= wb_next;
    wslot       <= wslot_next;
    full        <= full_next;
    if (in_valid && in_ready) begin
      vp  <= vaddr[dpt_pkg::VADDR_W-1:OFF_W];
      off <= vaddr[OFF_W-1:0];
      wr  <= is_write;
    end
    if (finish && !out_free) begin
      held <= res;
    end
    if (finish && out_free) begin
      out_res <= res;
      out_off <= off;
    end else if (state == S_HOLD && out_free) begin
      out_res <= held;
      out_off <= off;
    end
  end

  assign paddr        = {out_res.frame, out_off};
  assign fault        = out_res.fault;
  assign frame        = out_res.frame;
  assign evicted      = out_res.evicted;
  assign evicted_page = out_res.ev_page;
  assign write_back   = out_res.wb;
  assign write_slot   = out_res.wslot;
  assign read_in      = out_res.rd;
  assign read_slot    = out_res.rslot;
  assign swap_full    = out_res.full;

  a_hit_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !fault) |-> (!evicted && !write_back && !read_in && !swap_full))
    else $error("hit result carries fault side information");

  a_wb_needs_evict: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (write_back || swap_full)) |-> (evicted && !(write_back && swap_full)))
    else $error("write-back or swap full without a single eviction outcome");

  a_fill_marks_frame: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |=> fr_valid[$past(cur)])
    else $error("filled frame not marked valid");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL && !out_free) |=> (state == S_HOLD && !in_ready))
    else $error("result dropped while output register was busy");

endmodule

FILE: rtl/core/dpt_ram.sv
module dpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/dpt_slot_alloc.sv
module dpt_slot_alloc #(
  parameter int SWAP_SLOTS = dpt_pkg::SWAP_SLOTS_DEF,
  localparam int SLOT_W = $clog2(SWAP_SLOTS),
  localparam int CNT_W  = $clog2(SWAP_SLOTS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  output logic              avail,
  output logic [SLOT_W-1:0] slot
);

  logic [CNT_W-1:0] count;

  // The counter saturates at the slot count; once there, no slot is handed out.
  assign avail = (count < CNT_W'(SWAP_SLOTS));
  assign slot  = count[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (take && avail) begin
      count <= count + CNT_W'(1);
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(SWAP_SLOTS))
    else $error("swap slot counter passed the slot count");

  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    (take && avail) |=> (count == $past(count) + CNT_W'(1)))
    else $error("swap slot counter did not advance on allocation");

  a_count_holds: assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(count))
    else $error("swap slot counter moved without allocation");

endmodule

FILE: test/demand_paging_translator_tb.sv
module demand_paging_translator_tb;

  localparam int VADDR_W     = dpt_pkg::VADDR_W;
  localparam int OFFSET_BITS = dpt_pkg::OFFSET_BITS;
  localparam int VP_W        = dpt_pkg::VP_W;
  localparam int VIRT_PAGES  = dpt_pkg::VIRT_PAGES;
  localparam int FRAMES     = dpt_pkg::FRAMES_DEF;
  localparam int SWAP_SLOTS = dpt_pkg::SWAP_SLOTS_DEF;
  localparam int FRAME_W    = $clog2(FRAMES);
  localparam int SLOT_W     = $clog2(SWAP_SLOTS);
  localparam int HOT_PAGES  = 12;
  localparam int RUN_LIMIT  = 12 * 400000;

  typedef enum logic {
    POLICY_FIFO  = 1'b0,
    POLICY_CLOCK = 1'b1
  } policy_t;

  typedef struct packed {
    logic [VADDR_W-1:0] addr;
    logic               wr;
  } access_t;

  typedef struct packed {
    logic [FRAME_W+OFFSET_BITS-1:0] paddr;
    logic                           fault;
    logic [FRAME_W-1:0]             frame;
    logic                           evicted;
    logic [VP_W-1:0]                evicted_page;
    logic                           write_back;
    logic [SLOT_W-1:0]              write_slot;
    logic                           read_in;
    logic [SLOT_W-1:0]              read_slot;
    logic                           swap_full;
  } xlat_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [VADDR_W-1:0] vaddr = '0;
  logic is_write = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [FRAME_W+OFFSET_BITS-1:0] paddr;
  logic fault;
  logic [FRAME_W-1:0] frame;
  logic evicted;
  logic [VP_W-1:0] evicted_page;
  logic write_back;
  logic [SLOT_W-1:0] write_slot;
  logic read_in;
  logic [SLOT_W-1:0] read_slot;
  logic swap_full;

  demand_paging_translator u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .vaddr        (vaddr),
    .is_write     (is_write),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .paddr        (paddr),
    .fault        (fault),
    .frame        (frame),
    .evicted      (evicted),
    .evicted_page (evicted_page),
    .write_back   (write_back),
    .write_slot   (write_slot),
    .read_in      (read_in),
    .read_slot    (read_slot),
    .swap_full    (swap_full)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Shadow page table, frame owners and replacement state.
  bit                pg_resident   [VIRT_PAGES];
  bit                pg_slotted    [VIRT_PAGES];
  bit                pg_dirty      [VIRT_PAGES];
  bit                pg_referenced [VIRT_PAGES];
  bit [FRAME_W-1:0]  pg_frame      [VIRT_PAGES];
  bit [SLOT_W-1:0]   pg_slot       [VIRT_PAGES];
  bit                fr_valid      [FRAMES];
  bit [VP_W-1:0]     fr_page       [FRAMES];
  bit [FRAME_W-1:0]  hand;
  int unsigned       slots_issued;
  policy_t           policy = POLICY_FIFO;

  access_t      access_queue [$];
  xlat_result_t xlat_expected [$];
  access_t      next_access;
  xlat_result_t want;
  int           mismatches = 0;
  int           in_idle_pct = 24;
  int           out_idle_pct = 24;
  logic [VP_W-1:0] hot_pages [HOT_PAGES];

  function automatic logic [FRAME_W-1:0] advance_hand();
    logic [FRAME_W-1:0] f;
    f = hand;
    hand = (hand == FRAMES - 1) ? '0 : hand + 1'b1;
    return f;
  endfunction

  function automatic logic [FRAME_W-1:0] choose_victim();
    logic [FRAME_W-1:0] f;
    f = '0;
    if (policy == POLICY_FIFO) begin
      return advance_hand();
    end
    // Second chance: referenced owners lose their bit and are passed over.
    for (int n = 0; n < 2 * FRAMES + 1; n++) begin
      f = advance_hand();
      if (!fr_valid[f]) begin
        return f;
      end
      if (pg_referenced[fr_page[f]]) begin
        pg_referenced[fr_page[f]] = 1'b0;
      end else begin
        return f;
      end
    end
    return f;
  endfunction

  function automatic xlat_result_t translate_access(logic [VADDR_W-1:0] addr, logic wr);
    xlat_result_t r;
    logic [VP_W-1:0] vp;
    logic [VP_W-1:0] op;
    logic [FRAME_W-1:0] f;
    r = '0;
    vp = addr[VADDR_W-1:OFFSET_BITS];
    if (!pg_resident[vp]) begin
      r.fault = 1'b1;
      f = choose_victim();
      if (fr_valid[f]) begin
        op = fr_page[f];
        r.evicted = 1'b1;
        r.evicted_page = op;
        if (pg_slotted[op]) begin
          if (pg_dirty[op]) begin
            r.write_back = 1'b1;
            r.write_slot = pg_slot[op];
          end
        end else if (slots_issued < SWAP_SLOTS) begin
          pg_slot[op] = slots_issued[SLOT_W-1:0];
          pg_slotted[op] = 1'b1;
          slots_issued++;
          r.write_back = 1'b1;
          r.write_slot = pg_slot[op];
        end else begin
          r.swap_full = 1'b1;
        end
        pg_resident[op] = 1'b0;
        pg_dirty[op] = 1'b0;
        pg_referenced[op] = 1'b0;
      end
      if (pg_slotted[vp]) begin
        r.read_in = 1'b1;
        r.read_slot = pg_slot[vp];
      end
      pg_resident[vp] = 1'b1;
      pg_frame[vp] = f;
      pg_dirty[vp] = 1'b0;
      fr_valid[f] = 1'b1;
      fr_page[f] = vp;
    end
    f = pg_frame[vp];
    pg_referenced[vp] = 1'b1;
    if (wr) begin
      pg_dirty[vp] = 1'b1;
    end
    r.frame = f;
    r.paddr = {f, addr[OFFSET_BITS-1:0]};
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  // Driver: a new access is presented only when the previous one has been taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        xlat_expected.push_back(translate_access(vaddr, is_write));
      end
      if (!in_valid || in_ready) begin
        if (access_queue.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          next_access = access_queue.pop_front();
          in_valid  <= 1'b1;
          vaddr     <= next_access.addr;
          is_write  <= next_access.wr;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result transfer is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (xlat_expected.size() == 0) begin
          $error("result transfer with no access outstanding");
          mismatches++;
        end else begin
          want = xlat_expected.pop_front();
          check_field("paddr", 32'(want.paddr), 32'(paddr));
          check_field("fault", 32'(want.fault), 32'(fault));
          check_field("frame", 32'(want.frame), 32'(frame));
          check_field("evicted", 32'(want.evicted), 32'(evicted));
          check_field("evicted_page", 32'(want.evicted_page), 32'(evicted_page));
          check_field("write_back", 32'(want.write_back), 32'(write_back));
          check_field("write_slot", 32'(want.write_slot), 32'(write_slot));
          check_field("read_in", 32'(want.read_in), 32'(read_in));
          check_field("read_slot", 32'(want.read_slot), 32'(read_slot));
          check_field("swap_full", 32'(want.swap_full), 32'(swap_full));
        end
      end
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  task automatic queue_access(int unsigned addr, bit wr);
    access_t a;
    a.addr = addr[VADDR_W-1:0];
    a.wr = wr;
    access_queue.push_back(a);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (access_queue.size() != 0 || in_valid || xlat_expected.size() != 0);
  endtask

  task automatic write_policy(policy_t p);
    wait_drained();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= p;
    policy = p;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Most accesses hit a small working set a bit larger than the frame count,
  // so hits, clock sweeps and reloads from swap all keep occurring.
  task automatic queue_random_phase(int count);
    access_t a;
    int r;
    for (int i = 0; i < HOT_PAGES; i++) begin
      hot_pages[i] = VP_W'($urandom_range(VIRT_PAGES - 1));
    end
    for (int i = 0; i < count; i++) begin
      a.addr = VADDR_W'($urandom);
      a.wr = 1'($urandom_range(1));
      r = $urandom_range(99);
      if (r < 50) begin
        a.addr[VADDR_W-1:OFFSET_BITS] = hot_pages[4'($urandom_range(5))];
      end else if (r < 78) begin
        a.addr[VADDR_W-1:OFFSET_BITS] = hot_pages[4'($urandom_range(HOT_PAGES - 1, 6))];
      end
      access_queue.push_back(a);
    end
  endtask

  initial begin
    #(RUN_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    write_policy(POLICY_FIFO);

    // FIFO: lowest and highest address, a write hit, fill every frame, then
    // evict dirty pages without a slot and reload one from swap.
    queue_access(0, 1'b0);
    queue_access(8191, 1'b1);
    queue_access(3, 1'b1);
    for (int p = 1; p <= 6; p++) begin
      queue_access(p * 4 + p % 4, 1'(p % 2));
    end
    queue_access(7 * 4, 1'b0);
    queue_access(8 * 4 + 1, 1'b1);
    queue_access(0, 1'b0);
    queue_access(8 * 4 + 2, 1'b0);
    wait_drained();

    // Clock: every owner referenced forces a full sweep before a victim is found.
    write_policy(POLICY_CLOCK);
    queue_access(9 * 4, 1'b1);
    queue_access(7 * 4 + 3, 1'b1);
    queue_access(10 * 4, 1'b0);
    queue_access(8191, 1'b0);
    queue_access(0, 1'b1);
    queue_access(11 * 4 + 2, 1'b0);
    queue_access(4092, 1'b1);

    write_policy(POLICY_FIFO);
    queue_random_phase(350);
    write_policy(POLICY_CLOCK);
    in_idle_pct = 0;
    out_idle_pct = 0;
    queue_random_phase(300);
    write_policy(POLICY_FIFO);
    in_idle_pct = 24;
    out_idle_pct = 24;
    queue_random_phase(300);
    write_policy(POLICY_CLOCK);
    queue_random_phase(350);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: demand_paging_translator.f
rtl/core/dpt_pkg.sv
rtl/core/dpt_ram.sv
rtl/core/dpt_slot_alloc.sv
rtl/core/demand_paging_translator.sv
test/demand_paging_translator_tb.sv
